// ===== hw/rtl/hhv_pkg.sv =====
// Package for the Host header validator: per-element state type, phase codes,
// character constants and the configuration register indexes.
// No dependencies.
package hhv_pkg;

  localparam int unsigned HostLenW  = 9;
  localparam int unsigned QuadValW  = 9;
  localparam int unsigned LabelLenW = 7;
  localparam int unsigned PortValW  = 17;

  localparam logic [HostLenW-1:0]  HostLenMax  = 9'd511;
  localparam logic [2:0]           QuadPartMax = 3'd7;
  localparam logic [LabelLenW-1:0] LabelLenMax = 7'd127;
  localparam logic [QuadValW-1:0]  QuadClamp   = 9'd256;
  localparam logic [PortValW-1:0]  PortClamp   = 17'd65536;
  localparam logic [PortValW-1:0]  PortMax     = 17'd65535;

  // "localhost" match tracker
  localparam logic [3:0] KwLen  = 4'd9;
  localparam logic [3:0] KwDead = 4'd15;

  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLbrack = 8'h5B;
  localparam logic [7:0] ChRbrack = 8'h5D;
  localparam logic [7:0] ChHyphen = 8'h2D;

  // configuration register indexes
  localparam logic CfgMaxHost  = 1'b0;
  localparam logic CfgMaxLabel = 1'b1;

  localparam logic [7:0] MaxHostReset  = 8'd253;
  localparam logic [5:0] MaxLabelReset = 6'd63;

  typedef enum logic [2:0] {
    PhLead = 3'b001,
    PhHost = 3'b010,
    PhPort = 3'b100
  } phase_e;

  typedef struct packed {
    phase_e                phase;
    logic                  pending_blank;
    logic [HostLenW-1:0]   host_len;
    logic                  open_br;
    logic                  close_br;
    logic                  quad_ok;
    logic [2:0]            quad_parts;
    logic [QuadValW-1:0]   quad_value;
    logic                  quad_tok;
    logic                  name_ok;
    logic                  first_label;
    logic [LabelLenW-1:0]  label_len;
    logic                  label_end_alnum;
    logic                  label_alpha;
    logic [3:0]            kw_idx;
    logic                  kw_match;
    logic                  label_seen;
    logic                  port_ok;
    logic [PortValW-1:0]   port_value;
    logic                  port_present;
  } elem_t;

  localparam elem_t ElemReset = '{
    phase:           PhLead,
    pending_blank:   1'b0,
    host_len:        '0,
    open_br:         1'b0,
    close_br:        1'b0,
    quad_ok:         1'b1,
    quad_parts:      3'd0,
    quad_value:      '0,
    quad_tok:        1'b0,
    name_ok:         1'b1,
    first_label:     1'b1,
    label_len:       '0,
    label_end_alnum: 1'b0,
    label_alpha:     1'b1,
    kw_idx:          4'd0,
    kw_match:        1'b0,
    label_seen:      1'b0,
    port_ok:         1'b1,
    port_value:      '0,
    port_present:    1'b0
  };

endpackage

// ===== hw/rtl/hhv_step.sv =====
// Per-byte update of the Host header validator: next element state, running
// any-valid flag and the verdict at the final byte. Pure combinational.
// Depends on hhv_pkg.
module hhv_step (
  input  hhv_pkg::elem_t elem_i,
  input  logic           any_valid_i,
  input  logic [7:0]     byte_i,
  input  logic           end_i,
  input  logic [7:0]     max_host_i,
  input  logic [5:0]     max_label_i,
  output hhv_pkg::elem_t elem_o,
  output logic           any_valid_o,
  output logic           result_o
);
  import hhv_pkg::*;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic [7:0] kw_char(logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h6C;  // l
      4'd1:    r = 8'h6F;  // o
      4'd2:    r = 8'h63;  // c
      4'd3:    r = 8'h61;  // a
      4'd4:    r = 8'h6C;  // l
      4'd5:    r = 8'h68;  // h
      4'd6:    r = 8'h6F;  // o
      4'd7:    r = 8'h73;  // s
      4'd8:    r = 8'h74;  // t
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic elem_t close_label(elem_t s);
    elem_t r;
    logic  fits;
    r    = s;
    fits = s.label_len <= {1'b0, max_label_i};
    if (s.label_len == '0) begin
      r.name_ok = 1'b0;
    end else begin
      if (!fits) r.name_ok = 1'b0;
      if (s.first_label) begin
        if ((s.kw_idx == KwLen) && fits) r.kw_match = 1'b1;
        if (!s.label_alpha) r.name_ok = 1'b0;
        if (r.name_ok) r.label_seen = 1'b1;
      end else if (!s.label_end_alnum) begin
        r.name_ok = 1'b0;
      end
    end
    r.label_len       = '0;
    r.label_end_alnum = 1'b0;
    r.label_alpha     = 1'b1;
    r.first_label     = 1'b0;
    return r;
  endfunction

  function automatic elem_t label_char(elem_t s, logic [7:0] c);
    elem_t r;
    logic  alnum;
    r     = s;
    alnum = is_alpha(c) || is_digit(c);
    if (s.first_label) begin
      if (!is_alpha(c)) r.label_alpha = 1'b0;
      if ((s.kw_idx < KwLen) && (c == kw_char(s.kw_idx))) r.kw_idx = s.kw_idx + 4'd1;
      else r.kw_idx = KwDead;
    end else begin
      if ((s.label_len == '0) && !alnum) r.name_ok = 1'b0;
      if (!alnum && (c != ChHyphen)) r.name_ok = 1'b0;
    end
    r.label_end_alnum = alnum;
    if (s.label_len < LabelLenMax) r.label_len = s.label_len + 7'd1;
    return r;
  endfunction

  function automatic elem_t host_char(elem_t s, logic [7:0] c);
    elem_t       r;
    logic [11:0] v;
    r = s;
    v = {3'b0, s.quad_value} * 12'd10 + {8'b0, c[3:0]};
    if (s.host_len == '0) r.open_br = (c == ChLbrack);
    r.close_br = (c == ChRbrack);
    if (s.host_len < HostLenMax) r.host_len = s.host_len + 9'd1;
    if (c == ChDot) begin
      if (s.quad_parts < QuadPartMax) r.quad_parts = s.quad_parts + 3'd1;
      r.quad_value = '0;
      r.quad_tok   = 1'b0;
    end else if (is_digit(c)) begin
      if (v > 12'd255) begin
        r.quad_ok    = 1'b0;
        r.quad_value = QuadClamp;
      end else begin
        r.quad_value = v[QuadValW-1:0];
      end
      r.quad_tok = 1'b1;
    end else begin
      r.quad_ok = 1'b0;
    end
    if (c == ChDot) r = close_label(r);
    else r = label_char(r, c);
    return r;
  endfunction

  function automatic elem_t port_char(elem_t s, logic [7:0] c);
    elem_t       r;
    logic [19:0] v;
    r = s;
    v = {3'b0, s.port_value} * 20'd10 + {16'b0, c[3:0]};
    r.port_present = 1'b1;
    if (is_digit(c)) begin
      r.port_value = (v > {3'b0, PortClamp}) ? PortClamp : v[PortValW-1:0];
    end else begin
      r.port_ok = 1'b0;
    end
    return r;
  endfunction

  function automatic elem_t close_host(elem_t s);
    return (s.label_len != '0) ? close_label(s) : s;
  endfunction

  function automatic elem_t feed(elem_t s, logic [7:0] c);
    elem_t r;
    r = s;
    if (s.phase == PhHost) begin
      if (c == ChColon) begin
        r       = close_host(s);
        r.phase = PhPort;
      end else begin
        r = host_char(s, c);
      end
    end else begin
      r = port_char(s, c);
    end
    return r;
  endfunction

  // verdict on one finished element
  function automatic logic elem_ok(elem_t s);
    elem_t t;
    logic  quad_v;
    logic  br_v;
    logic  dom_v;
    logic  port_v;
    t      = (s.phase == PhHost) ? close_host(s) : s;
    quad_v = t.quad_ok && (({1'b0, t.quad_parts} + {3'b0, t.quad_tok}) == 4'd4);
    br_v   = t.open_br && t.close_br && (t.host_len >= 9'd2);
    dom_v  = (t.host_len >= 9'd1) && (t.host_len <= {1'b0, max_host_i}) &&
             (t.kw_match || (t.name_ok && t.label_seen));
    port_v = !t.port_present ||
             (t.port_ok && (t.port_value >= 17'd1) && (t.port_value <= PortMax));
    return (quad_v || br_v || dom_v) && port_v;
  endfunction

  elem_t s;
  logic  any;

  always_comb begin
    s        = elem_i;
    any      = any_valid_i;
    result_o = 1'b0;
    if (byte_i == ChComma) begin
      any = any | elem_ok(s);
      s   = ElemReset;
    end else if (s.phase == PhLead) begin
      if (!is_blank(byte_i)) begin
        s.phase = PhHost;
        s       = feed(s, byte_i);
      end
    end else if (is_blank(byte_i)) begin
      s.pending_blank = 1'b1;
    end else begin
      // a run of inner blanks counts as one space character
      if (s.pending_blank) begin
        s = (s.phase == PhHost) ? host_char(s, ChSpace) : port_char(s, ChSpace);
        s.pending_blank = 1'b0;
      end
      s = feed(s, byte_i);
    end
    if (end_i) begin
      if (byte_i != ChComma) any = any | elem_ok(s);
      result_o = any;
      any      = 1'b0;
      s        = ElemReset;
    end
  end

  assign elem_o      = s;
  assign any_valid_o = any;

endmodule

// ===== hw/rtl/http_host_header_validator.sv =====
// Host header validator top level: input register, per-byte state update,
// result register and the two configuration registers.
// Depends on hhv_pkg and hhv_step.
//
// Takes a Host header value one byte per transaction and returns one verdict
// (header_valid_o) per header, after the byte flagged by header_end_i. A byte
// is taken every clock cycle unless a final byte waits for room in the result
// register; each byte passes the input register and one combinational update
// of the element state, and the verdict is held in the result register. A
// stalled verdict stalls only the final byte of the next header; other bytes
// keep flowing. The user must write the limits max_host_length (index 0) and
// max_label_length (index 1) only while no header is in flight; the block does
// not enforce this. No initialization pass after reset.
module http_host_header_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_addr_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] header_byte_i,
  input  logic       header_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       header_valid_o
);
  import hhv_pkg::*;

  logic [7:0] max_host_q;
  logic [5:0] max_label_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  elem_t      elem_q, elem_d;
  logic       any_q, any_d;
  logic       result;

  logic       out_valid_q;
  logic       out_data_q;
  logic       proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_host_q  <= MaxHostReset;
      max_label_q <= MaxLabelReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgMaxHost:  max_host_q  <= cfg_wdata_i;
        CfgMaxLabel: max_label_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // only a final byte needs room in the result register
  assign proc       = in_valid_q && (!in_end_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= header_byte_i;
      in_end_q  <= header_end_i;
    end
  end

  hhv_step u_step (
    .elem_i      (elem_q),
    .any_valid_i (any_q),
    .byte_i      (in_byte_q),
    .end_i       (in_end_q),
    .max_host_i  (max_host_q),
    .max_label_i (max_label_q),
    .elem_o      (elem_d),
    .any_valid_o (any_d),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q <= ElemReset;
      any_q  <= 1'b0;
    end else if (proc) begin
      elem_q <= elem_d;
      any_q  <= any_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !out_ready_i) || (proc && in_end_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_end_q) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign header_valid_o = out_data_q;

endmodule
